@@ hdl/ctdt_pkg.sv @@
// Shared types for the calendar date to TAI seconds pipeline.
package ctdt_pkg;

  // Status codes on the result
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_YEAR  = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_BAD_DAY   = 2'd3
  } status_e;

  // Stage 1 -> stage 2: decoded date, offset year terms, time of day
  typedef struct packed {
    logic        yerr;
    logic        merr;
    logic        feb;
    logic [4:0]  mlen_base;
    logic [4:0]  day;
    logic [1:0]  y_low;
    logic [8:0]  mterm;
    logic [13:0] a;      // year - shift + 4712
    logic [13:0] c;      // year - shift + 4900
    logic [13:0] p;      // year + 4800, for the leap test
    logic [18:0] tod;    // signed, h*3600+m*60+s + tai - zone
  } dec_t;

  // Stage 2 -> stage 3: products of the constant multipliers
  typedef struct packed {
    logic        yerr;
    logic        merr;
    logic        feb;
    logic [4:0]  mlen_base;
    logic [4:0]  day;
    logic [1:0]  y_low;
    logic [8:0]  mterm;
    logic [13:0] p;
    logic [24:0] a_prod; // 1461 * a
    logic [7:0]  qc;     // c / 100
    logic [7:0]  qp;     // p / 100
    logic [18:0] tod;
  } prod_t;

  // Stage 3 -> stage 4: day count since the epoch and status
  typedef struct packed {
    logic        err;
    status_e     status;
    logic [23:0] days;   // signed
    logic [18:0] tod;
  } day_t;

  // Stage 4 -> stage 5: day count in seconds
  typedef struct packed {
    logic        err;
    status_e     status;
    logic [40:0] day_sec;
    logic [18:0] tod;
  } sec_t;

endpackage

@@ hdl/ctdt_dec.sv @@
// Stage 1: field checks, month tables, offset years and time of day.
module ctdt_dec import ctdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [7:0]  tai_minus_utc_i,
  input  logic [16:0] zone_offset_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dec_t        out_o
);

  localparam logic signed [13:0] MinYear = -14'sd4699;

  logic        valid_q, valid_d;
  dec_t        data_q, data_d;
  logic        shift;
  logic [14:0] ys;
  logic [14:0] y_ext;
  logic [16:0] hms;

  // month tables, checks, shifted year terms (Jan/Feb belong to the previous year)
  always_comb begin
    // day-count term of the MJD formula and month length
    data_d.mterm     = 9'd0;
    data_d.mlen_base = 5'd31;
    case (month_i)
      4'd1:    begin data_d.mterm = 9'd306; data_d.mlen_base = 5'd31; end
      4'd2:    begin data_d.mterm = 9'd337; data_d.mlen_base = 5'd28; end
      4'd3:    begin data_d.mterm = 9'd0;   data_d.mlen_base = 5'd31; end
      4'd4:    begin data_d.mterm = 9'd31;  data_d.mlen_base = 5'd30; end
      4'd5:    begin data_d.mterm = 9'd61;  data_d.mlen_base = 5'd31; end
      4'd6:    begin data_d.mterm = 9'd92;  data_d.mlen_base = 5'd30; end
      4'd7:    begin data_d.mterm = 9'd122; data_d.mlen_base = 5'd31; end
      4'd8:    begin data_d.mterm = 9'd153; data_d.mlen_base = 5'd31; end
      4'd9:    begin data_d.mterm = 9'd184; data_d.mlen_base = 5'd30; end
      4'd10:   begin data_d.mterm = 9'd214; data_d.mlen_base = 5'd31; end
      4'd11:   begin data_d.mterm = 9'd245; data_d.mlen_base = 5'd30; end
      4'd12:   begin data_d.mterm = 9'd275; data_d.mlen_base = 5'd31; end
      default: begin data_d.mterm = 9'd0;   data_d.mlen_base = 5'd31; end
    endcase

    shift        = (month_i == 4'd1) || (month_i == 4'd2);
    y_ext        = {year_i[13], year_i};
    ys           = y_ext - {14'd0, shift};
    data_d.yerr  = $signed(year_i) < MinYear;
    data_d.merr  = (month_i == 4'd0) || (month_i > 4'd12);
    data_d.feb   = month_i == 4'd2;
    data_d.day   = day_i;
    data_d.y_low = year_i[1:0];
    data_d.a     = 14'(ys + 15'd4712);
    data_d.c     = 14'(ys + 15'd4900);
    data_d.p     = 14'(y_ext + 15'd4800);
    hms          = 17'(hour_i) * 17'd3600 + 17'(minute_i) * 17'd60 + 17'(second_i);
    data_d.tod   = {2'b00, hms} + {11'd0, tai_minus_utc_i}
                 - {{2{zone_offset_seconds_i[16]}}, zone_offset_seconds_i};
  end

  // stage register
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

@@ hdl/ctdt_mjd.sv @@
// Stages 2 and 3: constant products, then day count and date status.
module ctdt_mjd import ctdt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  dec_t  in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output day_t  out_o
);

  // MJD - 40587 = A + M - B + day - 2440491
  localparam logic [24:0] DayBias = 25'd2440491;

  logic        p2_valid_q, p2_valid_d, p2_ready;
  prod_t       p2_q, p2_d;
  logic        p3_valid_q, p3_valid_d;
  day_t        p3_q, p3_d;
  logic [26:0] qc_full, qp_full;
  logic [22:0] a_term;
  logic [9:0]  b3;
  logic [13:0] rem;
  logic        leap;
  logic [4:0]  mlen;
  logic        bad_day;
  logic [24:0] days_w;

  // stage 2: 1461*a and the divisions by 100 as reciprocal products
  always_comb begin
    qc_full        = 27'(in_i.c) * 27'd5243;
    qp_full        = 27'(in_i.p) * 27'd5243;
    p2_d.yerr      = in_i.yerr;
    p2_d.merr      = in_i.merr;
    p2_d.feb       = in_i.feb;
    p2_d.mlen_base = in_i.mlen_base;
    p2_d.day       = in_i.day;
    p2_d.y_low     = in_i.y_low;
    p2_d.mterm     = in_i.mterm;
    p2_d.p         = in_i.p;
    p2_d.a_prod    = 25'(in_i.a) * 25'd1461;
    p2_d.qc        = qc_full[26:19];
    p2_d.qp        = qp_full[26:19];
    p2_d.tod       = in_i.tod;
  end

  assign in_ready_o = !p2_valid_q || p2_ready;
  assign p2_valid_d = in_ready_o ? in_valid_i : p2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= p2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      p2_q <= p2_d;
    end
  end

  // stage 3: leap rule, day check, day count
  always_comb begin
    a_term  = p2_q.a_prod[24:2];
    b3      = 10'(p2_q.qc) * 10'd3;
    rem     = p2_q.p - 14'(p2_q.qp) * 14'd100;
    leap    = (p2_q.y_low == 2'b00) && ((rem != 14'd0) || (p2_q.qp[1:0] == 2'b00));
    mlen    = p2_q.feb ? (leap ? 5'd29 : 5'd28) : p2_q.mlen_base;
    bad_day = (p2_q.day == 5'd0) || (p2_q.day > mlen);
    days_w  = {2'b00, a_term} + 25'(p2_q.mterm) - 25'(b3[9:2])
            + 25'(p2_q.day) - DayBias;
    p3_d.err  = p2_q.yerr || p2_q.merr;
    p3_d.days = days_w[23:0];
    p3_d.tod  = p2_q.tod;
    if (p2_q.yerr) begin
      p3_d.status = ST_BAD_YEAR;
    end else if (p2_q.merr) begin
      p3_d.status = ST_BAD_MONTH;
    end else if (bad_day) begin
      p3_d.status = ST_BAD_DAY;
    end else begin
      p3_d.status = ST_OK;
    end
  end

  assign p2_ready   = !p3_valid_q || out_ready_i;
  assign p3_valid_d = p2_ready ? p2_valid_q : p3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else begin
      p3_valid_q <= p3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_valid_q && p2_ready) begin
      p3_q <= p3_d;
    end
  end

  assign out_valid_o = p3_valid_q;
  assign out_o       = p3_q;

endmodule

@@ hdl/ctdt_sec.sv @@
// Stages 4 and 5: day count to seconds, time of day added, output register.
module ctdt_sec import ctdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  day_t        in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [40:0] tai_seconds_o,
  output status_e     status_o
);

  logic        p4_valid_q, p4_valid_d, p4_ready;
  sec_t        p4_q, p4_d;
  logic        p5_valid_q, p5_valid_d;
  logic [40:0] tai_q, tai_d;
  status_e     status_q;
  logic [40:0] days_x;

  // stage 4: days * 86400, modulo 2^41
  always_comb begin
    days_x       = {{17{in_i.days[23]}}, in_i.days};
    p4_d.err     = in_i.err;
    p4_d.status  = in_i.status;
    p4_d.day_sec = days_x * 41'd86400;
    p4_d.tod     = in_i.tod;
  end

  assign in_ready_o = !p4_valid_q || p4_ready;
  assign p4_valid_d = in_ready_o ? in_valid_i : p4_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else begin
      p4_valid_q <= p4_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      p4_q <= p4_d;
    end
  end

  // stage 5: add time of day; year or month error forces one
  assign tai_d = p4_q.err ? 41'd1
               : p4_q.day_sec + {{22{p4_q.tod[18]}}, p4_q.tod};

  assign p4_ready   = !p5_valid_q || out_ready_i;
  assign p5_valid_d = p4_ready ? p4_valid_q : p5_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_valid_q <= 1'b0;
    end else begin
      p5_valid_q <= p5_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p4_valid_q && p4_ready) begin
      tai_q    <= tai_d;
      status_q <= p4_q.status;
    end
  end

  assign out_valid_o   = p5_valid_q;
  assign tai_seconds_o = tai_q;
  assign status_o      = status_q;

endmodule

@@ hdl/calendar_date_to_tai_seconds.sv @@
// Top level: configuration registers and the five-stage date conversion pipeline.
//
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+---------------------------------------------
//  s_axis   | in        | tvalid / tready  | tdata: year, month, day, hour, minute, second
//  m_axis   | out       | tvalid / tready  | tdata: tai_seconds; tuser: status
//  apb      | in        | psel / penable   | 0x0 tai_minus_utc, 0x4 zone_offset_seconds
//
// One request per cycle sustained while the output is not stalled; the result sits in
// the output register, the last of five register stages. Each of the five stages
// holds its own valid bit and moves when the stage after it is free, so bubbles
// close up under a stall and the input keeps taking requests while a result waits,
// until all five stages are full. Reset clears the valid bits and loads the
// register defaults; no clearing pass.
module calendar_date_to_tai_seconds import ctdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // year[13:0], month[17:14], day[22:18],
                                      // hour[27:23], minute[33:28], second[39:34]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // tai_seconds[40:0], zero[47:41]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic RegTai  = 1'b0;
  localparam logic RegZone = 1'b1;

  logic [7:0]  tai_q, tai_d;
  logic [16:0] zone_q, zone_d;
  logic        wr_en;
  logic        dec_valid, dec_ready;
  dec_t        dec_data;
  logic        mjd_valid, mjd_ready;
  day_t        mjd_data;
  logic [40:0] tai_seconds;
  status_e     status;

  // register write and read
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    tai_d  = tai_q;
    zone_d = zone_q;
    prdata = 32'd0;
    unique case (paddr[2])
      RegTai: begin
        prdata = {24'd0, tai_q};
        if (wr_en) tai_d = pwdata[7:0];
      end
      RegZone: begin
        prdata = {{15{zone_q[16]}}, zone_q};
        if (wr_en) zone_d = pwdata[16:0];
      end
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tai_q  <= 8'd37;
      zone_q <= 17'd28800;
    end else begin
      tai_q  <= tai_d;
      zone_q <= zone_d;
    end
  end

  // stage 1
  ctdt_dec u_dec (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (s_axis_tvalid),
    .in_ready_o            (s_axis_tready),
    .year_i                (s_axis_tdata[13:0]),
    .month_i               (s_axis_tdata[17:14]),
    .day_i                 (s_axis_tdata[22:18]),
    .hour_i                (s_axis_tdata[27:23]),
    .minute_i              (s_axis_tdata[33:28]),
    .second_i              (s_axis_tdata[39:34]),
    .tai_minus_utc_i       (tai_q),
    .zone_offset_seconds_i (zone_q),
    .out_valid_o           (dec_valid),
    .out_ready_i           (dec_ready),
    .out_o                 (dec_data)
  );

  // stages 2 and 3
  ctdt_mjd u_mjd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec_data),
    .out_valid_o (mjd_valid),
    .out_ready_i (mjd_ready),
    .out_o       (mjd_data)
  );

  // stages 4 and 5
  ctdt_sec u_sec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (mjd_valid),
    .in_ready_o    (mjd_ready),
    .in_i          (mjd_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .tai_seconds_o (tai_seconds),
    .status_o      (status)
  );

  assign m_axis_tdata = {7'd0, tai_seconds};
  assign m_axis_tuser = status;

endmodule
